FILE: design/sgcu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgcu_pkg
// Shared widths for the sensor grid calibrate and upscale block.
// ----------------------------------------------------------------------------
package sgcu_pkg;

  localparam int VAL_W      = 24;
  localparam int RAW_W      = 16;
  localparam int ROW_PORT_W = 4;
  localparam int COL_PORT_W = 5;

endpackage

`default_nettype wire

FILE: design/sgcu_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgcu_div
// Divider by a fixed denominator using a reciprocal multiply in two passes.
// ----------------------------------------------------------------------------
module sgcu_div #(
  parameter int DEN_W = 9,
  parameter int DEN   = 465
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [DEN_W+sgcu_pkg::VAL_W-1:0] num,
  output logic                                done,
  output logic [sgcu_pkg::VAL_W-1:0]          quot
);

  localparam int NUM_W = DEN_W + sgcu_pkg::VAL_W;
  localparam int SHIFT = NUM_W + $clog2(DEN);
  localparam int MW    = NUM_W + 1;
  localparam int LO_W  = NUM_W / 2;
  localparam int HI_W  = NUM_W - LO_W;
  localparam int MP_W  = HI_W + MW;
  localparam int ACC_W = NUM_W + MW;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN);
  localparam logic [MW-1:0] RECIP_V = MW'(RECIP);

  logic              busy_r;
  logic              done_r;
  logic              phase_r;
  logic [NUM_W-1:0]  num_r;
  logic [ACC_W-1:0]  acc_r;
  logic [HI_W-1:0]   mul_a;
  logic [MP_W-1:0]   mul_p;

  assign mul_a = phase_r ? num_r[NUM_W-1:LO_W] : HI_W'(num_r[LO_W-1:0]);
  assign mul_p = MP_W'(mul_a) * MP_W'(RECIP_V);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= 1'b0;
      end else if (busy_r) begin
        if (phase_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        phase_r <= ~phase_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
    end else if (busy_r) begin
      if (phase_r) begin
        acc_r <= acc_r + (ACC_W'(mul_p) << LO_W);
      end else begin
        acc_r <= ACC_W'(mul_p);
      end
    end
  end

  assign done = done_r;
  assign quot = acc_r[SHIFT+sgcu_pkg::VAL_W-1:SHIFT];

endmodule

`default_nettype wire

FILE: design/sensor_grid_calibrate_upscale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_grid_calibrate_upscale
// Calibrates a sensor frame into a store and streams its bilinear upscale.
// ----------------------------------------------------------------------------
// Load transfer: busy for one cycle after the transfer. A new transfer of
// either kind is taken only while busy is low. Emit transfer: S_E0 to S_E7
// do the four store reads and six passes of the shared multiplier and start
// the two-pass reciprocal divider; S_WAIT registers out_valid once it is
// done. An emit with no complete frame gives nothing.
// Synchronous reset clears control state; the frame store is not cleared.
module sensor_grid_calibrate_upscale #(
  parameter int IN_W  = 16,
  parameter int IN_H  = 8,
  parameter int OUT_W = 32,
  parameter int OUT_H = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_mode,
  input  wire logic [sgcu_pkg::RAW_W-1:0]         in_raw_sample,
  input  wire logic [sgcu_pkg::RAW_W-1:0]         in_cell_offset,
  input  wire logic [sgcu_pkg::RAW_W-1:0]         in_cell_gain,
  output logic                                    out_valid,
  output logic [sgcu_pkg::ROW_PORT_W-1:0]         out_row,
  output logic [sgcu_pkg::COL_PORT_W-1:0]         out_col,
  output logic [sgcu_pkg::VAL_W-1:0]              out_pixel_value,
  output logic                                    out_last_of_frame
);

  localparam int CELLS   = IN_W * IN_H;
  localparam int AW      = $clog2(CELLS);
  localparam int XW      = $clog2(IN_W);
  localparam int YW      = $clog2(IN_H);
  localparam int CW      = $clog2(OUT_W);
  localparam int RW      = $clog2(OUT_H);
  localparam int DX      = OUT_W - 1;
  localparam int DY      = OUT_H - 1;
  localparam int DXW     = $clog2(OUT_W);
  localparam int DYW     = $clog2(OUT_H);
  localparam int WW      = (DXW > DYW) ? DXW : DYW;
  localparam int DW      = DXW + DYW;
  localparam int TW      = sgcu_pkg::VAL_W + DXW;
  localparam int SW      = sgcu_pkg::VAL_W + DW;
  localparam int PW      = TW + WW;
  localparam int DEN     = DX * DY;
  localparam int HALF    = DEN / 2;
  localparam int XQ_STEP = (IN_W - 1) / DX;
  localparam int XR_STEP = (IN_W - 1) % DX;
  localparam int YQ_STEP = (IN_H - 1) / DY;
  localparam int YR_STEP = (IN_H - 1) % DY;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_E0, S_E1, S_E2, S_E3, S_E4, S_E5, S_E6, S_E7, S_WAIT
  } state_t;

  state_t                       state_r;
  logic [AW-1:0]                widx_r;
  logic [AW-1:0]                wr_addr_r;
  logic                         frame_ready_r;
  logic [RW-1:0]                row_r;
  logic [CW-1:0]                col_r;
  logic [XW-1:0]                x0_r;
  logic [DXW-1:0]               xr_r;
  logic [YW-1:0]                y0_r;
  logic [DYW-1:0]               yr_r;
  logic                         out_valid_r;
  logic [sgcu_pkg::ROW_PORT_W-1:0] out_row_r;
  logic [sgcu_pkg::COL_PORT_W-1:0] out_col_r;
  logic [sgcu_pkg::VAL_W-1:0]   out_pixel_r;
  logic                         out_last_r;

  logic [sgcu_pkg::RAW_W-1:0]   diff_r;
  logic [sgcu_pkg::RAW_W-1:0]   gain_r;
  logic [2*sgcu_pkg::RAW_W-1:0] load_prod;

  logic [sgcu_pkg::VAL_W-1:0]   mem [CELLS];
  logic [sgcu_pkg::VAL_W-1:0]   rd_data_r;
  logic [AW-1:0]                rd_addr;

  logic [XW-1:0]                x1;
  logic [YW-1:0]                y1;
  logic [DXW-1:0]               wx0;
  logic [DYW-1:0]               wy0;
  logic [TW-1:0]                mul_a;
  logic [WW-1:0]                mul_b;
  logic [PW-1:0]                prod_r;
  logic [TW-1:0]                top_r;
  logic [TW-1:0]                bot_r;
  logic [SW-1:0]                sum_r;
  logic [SW-1:0]                div_num;
  logic                         div_done;
  logic [sgcu_pkg::VAL_W-1:0]   div_quot;

  logic                         accept;
  logic                         is_last;
  logic [AW-1:0]                load_base;
  logic [DXW:0]                 x_sum;
  logic [DYW:0]                 y_sum;

  function automatic logic [AW-1:0] cell_addr(input logic [YW-1:0] y,
                                              input logic [XW-1:0] x);
    return AW'(int'(y) * IN_W + int'(x));
  endfunction

  assign accept    = start && (state_r == S_IDLE);
  assign is_last   = (row_r == RW'(OUT_H - 1)) && (col_r == CW'(OUT_W - 1));
  assign load_base = frame_ready_r ? '0 : widx_r;
  assign x_sum     = (DXW+1)'(xr_r) + (DXW+1)'(XR_STEP);
  assign y_sum     = (DYW+1)'(yr_r) + (DYW+1)'(YR_STEP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      widx_r        <= '0;
      wr_addr_r     <= '0;
      frame_ready_r <= 1'b0;
      row_r         <= '0;
      col_r         <= '0;
      x0_r          <= '0;
      xr_r          <= '0;
      y0_r          <= '0;
      yr_r          <= '0;
      out_valid_r   <= 1'b0;
      out_row_r     <= '0;
      out_col_r     <= '0;
      out_pixel_r   <= '0;
      out_last_r    <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept && !in_mode) begin
            state_r   <= S_LOAD;
            wr_addr_r <= load_base;
            row_r     <= '0;
            col_r     <= '0;
            x0_r      <= '0;
            xr_r      <= '0;
            y0_r      <= '0;
            yr_r      <= '0;
            if (load_base == AW'(CELLS - 1)) begin
              widx_r        <= '0;
              frame_ready_r <= 1'b1;
            end else begin
              widx_r        <= load_base + 1'b1;
              frame_ready_r <= 1'b0;
            end
          end else if (accept && frame_ready_r) begin
            state_r <= S_E0;
          end
        end
        S_LOAD: state_r <= S_IDLE;
        S_E0:   state_r <= S_E1;
        S_E1:   state_r <= S_E2;
        S_E2:   state_r <= S_E3;
        S_E3:   state_r <= S_E4;
        S_E4:   state_r <= S_E5;
        S_E5:   state_r <= S_E6;
        S_E6:   state_r <= S_E7;
        S_E7:   state_r <= S_WAIT;
        S_WAIT: begin
          if (div_done) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            out_row_r   <= sgcu_pkg::ROW_PORT_W'(row_r);
            out_col_r   <= sgcu_pkg::COL_PORT_W'(col_r);
            out_pixel_r <= div_quot;
            out_last_r  <= is_last;
            if (is_last) begin
              frame_ready_r <= 1'b0;
              widx_r        <= '0;
              row_r         <= '0;
              col_r         <= '0;
              x0_r          <= '0;
              xr_r          <= '0;
              y0_r          <= '0;
              yr_r          <= '0;
            end else if (col_r == CW'(OUT_W - 1)) begin
              col_r <= '0;
              x0_r  <= '0;
              xr_r  <= '0;
              row_r <= row_r + 1'b1;
              if (y_sum >= (DYW+1)'(DY)) begin
                yr_r <= DYW'(y_sum - (DYW+1)'(DY));
                y0_r <= y0_r + YW'(YQ_STEP) + 1'b1;
              end else begin
                yr_r <= DYW'(y_sum);
                y0_r <= y0_r + YW'(YQ_STEP);
              end
            end else begin
              col_r <= col_r + 1'b1;
              if (x_sum >= (DXW+1)'(DX)) begin
                xr_r <= DXW'(x_sum - (DXW+1)'(DX));
                x0_r <= x0_r + XW'(XQ_STEP) + 1'b1;
              end else begin
                xr_r <= DXW'(x_sum);
                x0_r <= x0_r + XW'(XQ_STEP);
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      diff_r <= (in_raw_sample > in_cell_offset) ? in_raw_sample - in_cell_offset : '0;
      gain_r <= in_cell_gain;
    end
  end

  assign load_prod = diff_r * gain_r;

  always_ff @(posedge clk) begin
    if (state_r == S_LOAD) begin
      mem[wr_addr_r] <= load_prod[2*sgcu_pkg::RAW_W-1:8];
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign x1  = (x0_r == XW'(IN_W - 1)) ? x0_r : x0_r + 1'b1;
  assign y1  = (y0_r == YW'(IN_H - 1)) ? y0_r : y0_r + 1'b1;
  assign wx0 = DXW'(DX) - xr_r;
  assign wy0 = DYW'(DY) - yr_r;

  always_comb begin
    case (state_r)
      S_E0:    rd_addr = cell_addr(y0_r, x0_r);
      S_E1:    rd_addr = cell_addr(y0_r, x1);
      S_E2:    rd_addr = cell_addr(y1, x0_r);
      S_E3:    rd_addr = cell_addr(y1, x1);
      default: rd_addr = cell_addr(y0_r, x0_r);
    endcase
  end

  always_comb begin
    case (state_r)
      S_E1: begin
        mul_a = TW'(rd_data_r);
        mul_b = WW'(wx0);
      end
      S_E2: begin
        mul_a = TW'(rd_data_r);
        mul_b = WW'(xr_r);
      end
      S_E3: begin
        mul_a = TW'(rd_data_r);
        mul_b = WW'(wx0);
      end
      S_E4: begin
        mul_a = TW'(rd_data_r);
        mul_b = WW'(xr_r);
      end
      S_E5: begin
        mul_a = top_r;
        mul_b = WW'(wy0);
      end
      S_E6: begin
        mul_a = bot_r;
        mul_b = WW'(yr_r);
      end
      default: begin
        mul_a = TW'(rd_data_r);
        mul_b = WW'(wx0);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(mul_a) * PW'(mul_b);
    case (state_r)
      S_E2:    top_r <= TW'(prod_r);
      S_E3:    top_r <= top_r + TW'(prod_r);
      S_E4:    bot_r <= TW'(prod_r);
      S_E5:    bot_r <= bot_r + TW'(prod_r);
      S_E6:    sum_r <= SW'(prod_r);
      default: sum_r <= sum_r;
    endcase
  end

  assign div_num = sum_r + SW'(prod_r) + SW'(HALF);

  sgcu_div #(
    .DEN_W (DW),
    .DEN   (DEN)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_E7),
    .num   (div_num),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_pixel_value   = out_pixel_r;
  assign out_last_of_frame = out_last_r;

`ifndef SYNTH
  a_valid_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_WAIT))
    else $error("result strobe without a finished division");

  a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    !frame_ready_r |-> (row_r == '0 && col_r == '0 && x0_r == '0 && y0_r == '0))
    else $error("pixel counters moved without a ready frame");

  a_remainder_range: assert property (@(posedge clk) disable iff (!rst_n)
    (xr_r < DXW'(DX)) && (yr_r < DYW'(DY)))
    else $error("interpolation remainder out of range");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_WAIT))
    else $error("divider finished outside the wait state");
`endif

endmodule

`default_nettype wire
